[src/cpm_pkg.sv]
// Shared types, codes and the CRC-32 lookup table for the key-file pool mixer.
`default_nettype none
package cpm_pkg;

    localparam int READ_INDEX_W = 6;
    localparam int READ_SPAN    = 2 ** READ_INDEX_W;

    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_ABSORB = 2'd1,
        ACT_READ   = 2'd2
    } action_t;

    typedef struct packed {
        action_t                   action;
        logic [7:0]                data_byte;
        logic                      first_in_file;
        logic [READ_INDEX_W-1:0]   read_index;
        logic [7:0]                pass_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0]  mixed_byte;
        logic [31:0] crc_now;
    } out_item_t;

    // Write-side command into the pool storage
    typedef struct packed {
        logic wr_en;
        logic clear;
    } pool_cmd_t;

    typedef logic [31:0] crc_table_t [256];

    // Built at elaboration; byte-wise reflected CRC table
    function automatic crc_table_t crc_table_gen();
        crc_table_t  t;
        logic [31:0] c;
        for (int i = 0; i < 256; i++) begin
            c = 32'(i);
            for (int b = 0; b < 8; b++) begin
                c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
            end
            t[i] = c;
        end
        return t;
    endfunction

    localparam crc_table_t CRC_TABLE = crc_table_gen();

    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
        logic [7:0] idx;
        idx = crc[7:0] ^ data;
        return (crc >> 8) ^ CRC_TABLE[idx];
    endfunction

endpackage
`default_nettype wire

[src/cpm_in_if.sv]
// Input item channel: valid/ready handshake with the input item payload.
`default_nettype none
interface cpm_in_if;
    logic              valid;
    logic              ready;
    cpm_pkg::in_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[src/cpm_out_if.sv]
// Result item channel: valid/ready handshake with the result payload.
`default_nettype none
interface cpm_out_if;
    logic               valid;
    logic               ready;
    cpm_pkg::out_item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[src/crc32_keyfile_pool_mixer_core.sv]
// Top level of the key-file pool mixer: CRC-32 absorb, pool update and mixed reads.
`default_nettype none
// Key-file pool mixer. Each transaction on item_ch carries one action: clear
// the pool, absorb a key-file byte, or read one pool byte mixed with a
// passphrase byte. An absorb steps a reflected CRC-32 (poly 0xEDB88320, init
// all ones when first_in_file is set, no final inversion) and adds the four
// CRC bytes, most significant first, into the pool at the rotating word
// position. Every input transaction yields exactly one result transaction on
// result_ch carrying mixed_byte (zero unless a read) and the running CRC.
// Throughput is one transaction per cycle while result_ch is ready. The pool
// memory read is registered at accept alongside the execute stage, and
// the CRC table lookup, pool byte adds and pool write-back happen in the
// execute stage, which loads the result register. A waiting result does
// not block the next input from entering an empty execute stage.
// The pool is held as rows of four bytes; a pool size that is not a multiple
// of four keeps the wrapped tail bytes in the last row and folds them in on
// read. Clear acts through per-row valid bits; no
// clearing pass runs after reset.
module crc32_keyfile_pool_mixer_core #(
    parameter int POOL_BYTES = 64
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    cpm_in_if.sink     item_ch,
    cpm_out_if.source  result_ch
);

    localparam int ROWS  = (POOL_BYTES + 3) / 4;
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int IDX_W = $clog2(POOL_BYTES);
    localparam int PAD   = 4 * ROWS - POOL_BYTES;
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROWS - 1);
    localparam logic [1:0]       POOL_LANE = 2'(POOL_BYTES % 4);

    // read_index modulo pool size, worked out at elaboration
    logic [IDX_W-1:0] mod_lut [cpm_pkg::READ_SPAN];
    for (genvar i = 0; i < cpm_pkg::READ_SPAN; i++) begin : g_mod
        assign mod_lut[i] = IDX_W'(i % POOL_BYTES);
    end

    // Execute stage and result register
    logic                s1_valid_reg;
    cpm_pkg::in_item_t   s1_item_reg;
    logic [IDX_W-1:0]    s1_idx_reg;
    logic                out_valid_reg;
    cpm_pkg::out_item_t  out_item_reg;
    logic [31:0]         crc_reg;
    logic [31:0]         crc_next;
    logic [ROW_W-1:0]    wp_reg;
    logic [ROW_W-1:0]    wp_next;

    logic                in_fire;
    logic                s1_go;
    logic [IDX_W-1:0]    in_idx;
    logic [ROW_W-1:0]    rd_row;

    logic [ROW_W-1:0]    eff_wp;
    logic [ROW_W-1:0]    wp_inc;
    logic [31:0]         crc_base;
    logic [31:0]         crc_new;
    logic [31:0]         row_word;
    logic [31:0]         tail_word;
    logic [31:0]         new_word;
    logic [1:0]          lane;
    logic [1:0]          tail_lane;
    logic [7:0]          pool_byte;
    logic [7:0]          tail_byte;
    cpm_pkg::pool_cmd_t  cmd;
    cpm_pkg::out_item_t  result;

    assign s1_go         = s1_valid_reg && (!out_valid_reg || result_ch.ready);
    assign item_ch.ready = !s1_valid_reg || s1_go;
    assign in_fire       = item_ch.valid && item_ch.ready;

    assign result_ch.valid   = out_valid_reg;
    assign result_ch.payload = out_item_reg;

    // Row to read for the incoming transaction; word position follows the
    // transaction leaving execute at this same edge
    assign in_idx = mod_lut[item_ch.payload.read_index];
    always_comb begin
        case (item_ch.payload.action)
            cpm_pkg::ACT_ABSORB: rd_row = item_ch.payload.first_in_file ? '0 : wp_next;
            default:             rd_row = ROW_W'(in_idx >> 2);
        endcase
    end

    // Execute: CRC step, pool word update, mixed read
    assign eff_wp   = s1_item_reg.first_in_file ? '0 : wp_reg;
    assign wp_inc   = (eff_wp == LAST_ROW) ? '0 : eff_wp + 1'b1;
    assign crc_base = s1_item_reg.first_in_file ? cpm_pkg::CRC_INIT : crc_reg;
    assign crc_new  = cpm_pkg::crc32_byte(crc_base, s1_item_reg.data_byte);

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            new_word[8*k +: 8] = row_word[8*k +: 8] + crc_new[31 - 8*k -: 8];
        end
    end

    // Wrapped tail bytes of a non-multiple-of-four pool live in the last row
    assign lane      = s1_idx_reg[1:0];
    assign tail_lane = lane + POOL_LANE;
    assign pool_byte = row_word[8*lane +: 8];
    assign tail_byte = (s1_idx_reg < IDX_W'(PAD)) ? tail_word[8*tail_lane +: 8] : 8'd0;

    always_comb begin
        cmd             = '0;
        wp_next         = wp_reg;
        crc_next        = crc_reg;
        result.mixed_byte = 8'd0;
        result.crc_now  = crc_reg;
        case (s1_item_reg.action)
            cpm_pkg::ACT_CLEAR: begin
                cmd.clear = s1_go;
            end
            cpm_pkg::ACT_ABSORB: begin
                cmd.wr_en      = s1_go;
                result.crc_now = crc_new;
                if (s1_go) begin
                    wp_next  = wp_inc;
                    crc_next = crc_new;
                end
            end
            cpm_pkg::ACT_READ: begin
                result.mixed_byte = pool_byte + tail_byte + s1_item_reg.pass_byte;
            end
            default: begin
                // unused action code: no state change, zero mixed byte
            end
        endcase
    end

    cpm_pool #(
        .POOL_BYTES (POOL_BYTES)
    ) u_pool (
        .clk       (clk),
        .rst_n     (rst_n),
        .rd_en     (in_fire),
        .rd_row    (rd_row),
        .cmd       (cmd),
        .wr_row    (eff_wp),
        .wr_word   (new_word),
        .row_word  (row_word),
        .tail_word (tail_word)
    );

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            crc_reg       <= cpm_pkg::CRC_INIT;
            wp_reg        <= '0;
        end else begin
            crc_reg <= crc_next;
            wp_reg  <= wp_next;
            if (in_fire) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_go) begin
                out_valid_reg <= 1'b1;
            end else if (result_ch.ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (in_fire) begin
            s1_item_reg <= item_ch.payload;
            s1_idx_reg  <= in_idx;
        end
        if (s1_go) begin
            out_item_reg <= result;
        end
    end

endmodule
`default_nettype wire

[src/cpm_pool.sv]
// Pool storage: word-wide memory with per-row valid bits and a write bypass.
`default_nettype none
module cpm_pool #(
    parameter int POOL_BYTES = 64,
    localparam int ROWS  = (POOL_BYTES + 3) / 4,
    localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                rd_en,
    input  wire logic [ROW_W-1:0]    rd_row,
    input  wire cpm_pkg::pool_cmd_t  cmd,
    input  wire logic [ROW_W-1:0]    wr_row,
    input  wire logic [31:0]         wr_word,
    output logic      [31:0]         row_word,
    output logic      [31:0]         tail_word
);

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

    logic [31:0]      mem [ROWS];
    logic [31:0]      a_data_reg;
    logic [31:0]      b_data_reg;
    logic [ROW_W-1:0] a_row_reg;
    logic [ROWS-1:0]  valid_reg;
    logic             byp_valid_reg;
    logic [ROW_W-1:0] byp_row_reg;
    logic [31:0]      byp_word_reg;

    // Registered reads taken at the accept edge; a write may land at the same edge
    always_ff @(posedge clk) begin
        if (cmd.wr_en) begin
            mem[wr_row] <= wr_word;
        end
        if (rd_en) begin
            a_data_reg <= mem[rd_row];
            b_data_reg <= mem[LAST_ROW];
            a_row_reg  <= rd_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end else begin
            if (cmd.clear) begin
                valid_reg <= '0;
            end else if (cmd.wr_en) begin
                valid_reg[wr_row] <= 1'b1;
            end
            if (cmd.wr_en) begin
                byp_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.wr_en) begin
            byp_row_reg  <= wr_row;
            byp_word_reg <= wr_word;
        end
    end

    // Cleared rows read zero; last write overrides a read captured alongside it
    always_comb begin
        if (!valid_reg[a_row_reg]) begin
            row_word = '0;
        end else if (byp_valid_reg && (byp_row_reg == a_row_reg)) begin
            row_word = byp_word_reg;
        end else begin
            row_word = a_data_reg;
        end

        if (!valid_reg[LAST_ROW]) begin
            tail_word = '0;
        end else if (byp_valid_reg && (byp_row_reg == LAST_ROW)) begin
            tail_word = byp_word_reg;
        end else begin
            tail_word = b_data_reg;
        end
    end

endmodule
`default_nettype wire
